/* hw/rtl/ldgf_pkg.sv */
package ldgf_pkg;

    localparam int LEVEL_W           = 8;
    localparam int DUR_FIELD_W       = 24;
    localparam int DURATION_BITS_DEF = 24;

    typedef enum logic [2:0] {
        OP_SET      = 3'd0,
        OP_ON       = 3'd1,
        OP_OFF      = 3'd2,
        OP_TOGGLE   = 3'd3,
        OP_INCREASE = 3'd4,
        OP_DECREASE = 3'd5,
        OP_FADE_TO  = 3'd6,
        OP_TICK     = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_ctrl_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic tick_mid;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    typedef logic [255:0][LEVEL_W-1:0] t_gamma;

    // round(255 * (i/255)^2.2), found by exact integer comparison:
    // gamma(i) > v exactly when 1024 * i^22 >= (2v+1)^10 * 255^12
    function automatic t_gamma gamma_table();
        t_gamma      tbl;
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [191:0] base12;
        int unsigned v;
        logic        done;
        base12 = 192'd1;
        for (int k = 0; k < 12; k++) base12 = base12 * 192'd255;
        v = 0;
        for (int i = 0; i < 256; i++) begin
            lhs = 192'd1024;
            for (int k = 0; k < 22; k++) lhs = lhs * 192'(i);
            done = 1'b0;
            while (!done && v < 255) begin
                rhs = base12;
                for (int k = 0; k < 10; k++) rhs = rhs * 192'(2 * v + 1);
                if (lhs >= rhs) begin
                    v++;
                end else begin
                    done = 1'b1;
                end
            end
            tbl[i] = LEVEL_W'(v);
        end
        return tbl;
    endfunction

    localparam t_gamma GAMMA_ROM = gamma_table();

endpackage

/* hw/rtl/ldgf_cmd_if.sv */
interface ldgf_cmd_if import ldgf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_op                    op;
    logic [LEVEL_W-1:0]     value;
    logic [DUR_FIELD_W-1:0] duration;

    modport source (output valid, op, value, duration, input ready);
    modport sink   (input valid, op, value, duration, output ready);
endinterface

/* hw/rtl/ldgf_res_if.sv */
interface ldgf_res_if import ldgf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] duty;
    logic [LEVEL_W-1:0] brightness;
    logic               is_lit;
    logic               is_fading;

    modport source (output valid, duty, brightness, is_lit, is_fading, input ready);
    modport sink   (input valid, duty, brightness, is_lit, is_fading, output ready);
endinterface

/* hw/rtl/led_dimmer_gamma_fade.sv */
// Sequence: an accepted request goes through decode and then finish, where it
//   commits once the result slot is free; a tick in mid-fade adds one multiply
//   and 8 restoring divide steps. A new request is taken only after the last
//   has committed; the 8-step serial divide makes a mid-fade tick the slower case.
// Reset: synchronous, active low; level, lamp and fade state clear to zero.
//   The gamma table is constant logic and needs no fill after reset.
module led_dimmer_gamma_fade import ldgf_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldgf_cmd_if.sink   i_cmd,
    ldgf_res_if.source o_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequence each request: latch it, decide whether a fade step needs the
    // divider, run the multiply and divide, then commit once the result slot
    // is free. The next request is taken while a result still waits.
    ldgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Hold lamp and fade state, interpolate the fade level, look up the
    // gamma-corrected duty and keep the result register.
    ldgf_dp #(
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_op         (i_cmd.op),
        .i_value      (i_cmd.value),
        .i_duration   (i_cmd.duration),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_duty       (o_res.duty),
        .o_brightness (o_res.brightness),
        .o_is_lit     (o_res.is_lit),
        .o_is_fading  (o_res.is_fading)
    );

endmodule

/* hw/rtl/ldgf_ctrl.sv */
module ldgf_ctrl import ldgf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_state = i_sts.tick_mid ? ST_MUL : ST_FIN;
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: ;
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_FIN: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: ;
        endcase
    end

    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_DECODE)
        else $error("accepted request did not reach decode");

    a_mul_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul |=> o_cmd.div_step)
        else $error("multiply not followed by divide");

    a_div_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_sts.div_last) |=> r_state == ST_FIN)
        else $error("divide did not finish after last bit");

endmodule

/* hw/rtl/ldgf_dp.sv */
module ldgf_dp import ldgf_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  t_op                    i_op,
    input  logic [LEVEL_W-1:0]     i_value,
    input  logic [DUR_FIELD_W-1:0] i_duration,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [LEVEL_W-1:0]     o_duty,
    output logic [LEVEL_W-1:0]     o_brightness,
    output logic                   o_is_lit,
    output logic                   o_is_fading
);

    localparam int NumW  = DURATION_BITS + LEVEL_W;
    localparam int WideW = (DURATION_BITS > DUR_FIELD_W) ? DURATION_BITS : DUR_FIELD_W;

    // latched request
    t_op                      r_op;
    logic [LEVEL_W-1:0]       r_val;
    logic [DURATION_BITS-1:0] r_dur;

    // lamp and fade state
    logic [LEVEL_W-1:0]       r_level,        n_level;
    logic                     r_lamp_on,      n_lamp_on;
    logic                     r_fade_active,  n_fade_active;
    logic [LEVEL_W-1:0]       r_fade_from,    n_fade_from;
    logic [LEVEL_W-1:0]       r_fade_goal,    n_fade_goal;
    logic [DURATION_BITS-1:0] r_fade_elapsed, n_fade_elapsed;
    logic [DURATION_BITS-1:0] r_fade_length,  n_fade_length;

    // serial divide
    logic [NumW-1:0]          r_num;
    logic [LEVEL_W-1:0]       r_quot;
    logic [2:0]               r_bit;

    // result register
    logic                     r_out_valid;
    logic [LEVEL_W-1:0]       r_duty;
    logic [LEVEL_W-1:0]       r_bright;
    logic                     r_lit;
    logic                     r_fading;

    logic [WideW-1:0]         dur_wide;
    logic [DURATION_BITS-1:0] elapsed_inc;
    logic                     fade_up;
    logic [LEVEL_W-1:0]       fade_span;
    logic                     tick_mid;
    logic [NumW-1:0]          product;
    logic [NumW-1:0]          divisor_sh;
    logic                     trial_ok;
    logic [LEVEL_W-1:0]       quot_up;
    logic [LEVEL_W:0]         inc_sum;
    logic                     do_set;
    logic [LEVEL_W-1:0]       set_lvl;
    logic [LEVEL_W-1:0]       n_duty;

    assign dur_wide    = WideW'(i_duration);
    assign elapsed_inc = r_fade_elapsed + DURATION_BITS'(1);
    assign fade_up     = r_fade_goal >= r_fade_from;
    assign fade_span   = fade_up ? (r_fade_goal - r_fade_from) : (r_fade_from - r_fade_goal);
    assign tick_mid    = r_fade_active && (elapsed_inc < r_fade_length);
    assign product     = NumW'(fade_span) * NumW'(elapsed_inc);
    assign divisor_sh  = NumW'(r_fade_length) << r_bit;
    assign trial_ok    = r_num >= divisor_sh;
    // round toward the goal value when fading down
    assign quot_up     = r_quot + LEVEL_W'(r_num != '0);
    assign inc_sum     = {1'b0, r_level} + {1'b0, r_val};

    // only a tick in mid-fade needs the divider
    assign o_sts.tick_mid = tick_mid && (r_op == OP_TICK);
    assign o_sts.div_last = r_bit == 3'd0;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_level        = r_level;
        n_lamp_on      = r_lamp_on;
        n_fade_active  = r_fade_active;
        n_fade_from    = r_fade_from;
        n_fade_goal    = r_fade_goal;
        n_fade_elapsed = r_fade_elapsed;
        n_fade_length  = r_fade_length;
        do_set         = 1'b0;
        set_lvl        = r_val;
        unique case (r_op)
            OP_SET: begin
                do_set = 1'b1;
            end
            OP_ON: begin
                n_fade_active = 1'b0;
                n_lamp_on     = 1'b1;
            end
            OP_OFF: begin
                n_fade_active = 1'b0;
                n_lamp_on     = 1'b0;
            end
            OP_TOGGLE: begin
                n_fade_active = 1'b0;
                n_lamp_on     = !r_lamp_on;
            end
            OP_INCREASE: begin
                do_set  = 1'b1;
                set_lvl = inc_sum[LEVEL_W] ? '1 : inc_sum[LEVEL_W-1:0];
            end
            OP_DECREASE: begin
                do_set  = 1'b1;
                set_lvl = (r_val > r_level) ? '0 : (r_level - r_val);
            end
            OP_FADE_TO: begin
                if (r_val != r_level) begin
                    if (r_dur == '0) begin
                        do_set = 1'b1;
                    end else begin
                        n_fade_from    = r_level;
                        n_fade_goal    = r_val;
                        n_fade_elapsed = '0;
                        n_fade_length  = r_dur;
                        n_fade_active  = 1'b1;
                        if (r_val != '0) n_lamp_on = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_fade_active) begin
                    n_fade_elapsed = elapsed_inc;
                    if (!tick_mid) begin
                        do_set  = 1'b1;
                        set_lvl = r_fade_goal;
                    end else if (fade_up) begin
                        n_level = r_fade_from + r_quot;
                    end else begin
                        n_level = r_fade_from - quot_up;
                    end
                end
            end
            default: ;
        endcase
        if (do_set) begin
            n_fade_active = 1'b0;
            n_level       = set_lvl;
            n_lamp_on     = set_lvl != '0;
        end
    end

    assign n_duty = n_lamp_on ? GAMMA_ROM[n_level] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= '0;
            r_lamp_on      <= 1'b0;
            r_fade_active  <= 1'b0;
            r_fade_from    <= '0;
            r_fade_goal    <= '0;
            r_fade_elapsed <= '0;
            r_fade_length  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_level        <= n_level;
                r_lamp_on      <= n_lamp_on;
                r_fade_active  <= n_fade_active;
                r_fade_from    <= n_fade_from;
                r_fade_goal    <= n_fade_goal;
                r_fade_elapsed <= n_fade_elapsed;
                r_fade_length  <= n_fade_length;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= i_value;
            r_dur <= dur_wide[DURATION_BITS-1:0];
        end
        if (i_cmd.mul) begin
            r_num  <= product;
            r_quot <= '0;
            r_bit  <= 3'd7;
        end else if (i_cmd.div_step) begin
            if (trial_ok) begin
                r_num         <= r_num - divisor_sh;
                r_quot[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 3'd1;
        end
        if (i_cmd.commit) begin
            r_duty   <= n_duty;
            r_bright <= n_level;
            r_lit    <= n_lamp_on;
            r_fading <= n_fade_active;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_duty       = r_duty;
    assign o_brightness = r_bright;
    assign o_is_lit     = r_lit;
    assign o_is_fading  = r_fading;

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_out_valid && r_bright == r_level && r_lit == r_lamp_on
                          && r_fading == r_fade_active))
        else $error("result does not match committed state");

    a_dark_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_lit) |-> r_duty == '0)
        else $error("duty nonzero with lamp off");

    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fade_active |-> r_fade_elapsed < r_fade_length)
        else $error("fade elapsed reached length while fading");

endmodule
